@@ rtl/mf3rgb_pkg.sv @@
// Shared types, constants and compare helpers for the 3x3 RGB median filter.
`default_nettype none
package mf3rgb_pkg;
	localparam int CH_W  = 8;   // bits per color channel
	localparam int CFG_W = 12;  // frame size register width
	localparam int ROW_W = 13;  // row counter; one row past the frame during flush

	// opcode of an input word
	localparam logic OP_PIXEL = 1'b0;

	// register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

	// channel order inside a pixel word: [2] red, [1] green, [0] blue
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [2:0][CH_W-1:0] pix_t;
	typedef logic [2:0][CH_W-1:0] trio_t;

	function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [CH_W-1:0] min2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [CH_W-1:0] max3(input trio_t t);
		return max2(max2(t[0], t[1]), t[2]);
	endfunction

	function automatic logic [CH_W-1:0] min3(input trio_t t);
		return min2(min2(t[0], t[1]), t[2]);
	endfunction

	function automatic logic [CH_W-1:0] med3(input trio_t t);
		return max2(min2(t[0], t[1]), min2(max2(t[0], t[1]), t[2]));
	endfunction

	// ascending sort of three values: [0] low, [1] middle, [2] high
	function automatic trio_t sort3(input trio_t t);
		trio_t s;
		s[0] = min3(t);
		s[1] = med3(t);
		s[2] = max3(t);
		return s;
	endfunction
endpackage
`default_nettype wire

@@ rtl/mf3rgb_if.sv @@
// Stream interfaces for pixel input words and filtered output words.
`default_nettype none
interface mf3rgb_in_if;
	import mf3rgb_pkg::*;
	logic            valid;
	logic            ready;
	logic            opcode;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;
	modport source (output valid, output opcode, output in_red, output in_green,
		output in_blue, input ready);
	modport sink (input valid, input opcode, input in_red, input in_green,
		input in_blue, output ready);
endinterface

interface mf3rgb_out_if;
	import mf3rgb_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic            frame_end;
	modport source (output valid, output out_red, output out_green, output out_blue,
		output frame_end, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/median_filter_3x3_rgb_core.sv @@
// Top level of the 3x3 RGB median filter with line buffer memory and window.
//
// channel   dir  handshake       word
// pix_in    in   valid/ready     opcode, in_red, in_green, in_blue
// pix_out   out  valid/ready     out_red, out_green, out_blue, frame_end
// cfg       in   cfg_we          cfg_index, cfg_data (frame_width, frame_height)
//
// One input word per clock unless the output stalls or geometry is rebuilt;
// a word's result passes memory read, window shift, column sort, median +
// output register. The line buffer memory is read in the accept cycle and
// written when stage 1 advances; a write/read of the same column in adjacent
// words is forwarded. After reset and each config write the frame geometry
// is rebuilt, with no word taken meanwhile. A stalled output freezes the pipe.
`default_nettype none
module median_filter_3x3_rgb_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire                            cfg_index,
	input  wire [mf3rgb_pkg::CFG_W-1:0]    cfg_data,
	mf3rgb_in_if.sink                      pix_in,
	mf3rgb_out_if.source                   pix_out
);
	import mf3rgb_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);      // column index
	localparam int WW = $clog2(MAX_WIDTH + 1);  // effective width value
	localparam int NW = WW + ROW_W;             // raster position

	// ---------------- configuration and geometry ----------------
	logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
	logic [1:0]       recalc_q;
	logic [WW-1:0]    w_q;
	logic [CW-1:0]    wm1_q;
	logic [ROW_W-1:0] hm1_q;
	logic [NW-1:0]    w1_q, p_q, pw_q;

	logic [WW-1:0]    weff;
	logic [CFG_W-1:0] heff;

	always_comb begin
		if (cfg_w_q == '0)
			weff = WW'(1);
		else if (NW'(cfg_w_q) > NW'(MAX_WIDTH))
			weff = WW'(MAX_WIDTH);
		else
			weff = WW'(cfg_w_q);
		heff = (cfg_h_q == '0) ? CFG_W'(1) : cfg_h_q;
	end

	// ---------------- raster counters ----------------
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [NW-1:0]    rowbase_q;  // row_q * width

	logic adv, take;
	assign adv          = !pix_out.valid || pix_out.ready;
	assign pix_in.ready = adv && (recalc_q == 2'd0);
	assign take         = pix_in.valid && pix_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q  <= FRAME_WIDTH_RST;
			cfg_h_q  <= FRAME_HEIGHT_RST;
			recalc_q <= 2'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_w_q <= cfg_data;
				REG_FRAME_HEIGHT: cfg_h_q <= cfg_data;
				default:          cfg_w_q <= cfg_data;
			endcase
			recalc_q <= 2'd2;
		end else if (recalc_q != 2'd0) begin
			recalc_q <= recalc_q - 2'd1;
		end
	end

	// geometry: products are registered first, then their sum
	always_ff @(posedge clk) begin
		if (recalc_q == 2'd2) begin
			w_q   <= weff;
			wm1_q <= CW'(weff - WW'(1));
			hm1_q <= ROW_W'(heff - CFG_W'(1));
			w1_q  <= NW'(weff) + NW'(1);
			p_q   <= NW'(weff) * NW'(heff);
		end else if (recalc_q == 2'd1) begin
			pw_q <= p_q + NW'(w_q);
		end
	end

	// ---------------- accept stage decode ----------------
	logic [NW-1:0]    n_raw, n_a;
	logic             restart;
	logic [CW-1:0]    col_a;
	logic [ROW_W-1:0] row_a, rk_a;
	logic [NW-1:0]    rb_a;
	logic [CW-1:0]    ck_a;
	logic             in_frame, is_pix, proc_a, emit_a, last_a, border_a, wrap_a;
	pix_t             pix_a;

	always_comb begin
		n_raw   = rowbase_q + NW'(col_q);
		restart = n_raw > pw_q;
		col_a   = restart ? '0 : col_q;
		row_a   = restart ? '0 : row_q;
		rb_a    = restart ? '0 : rowbase_q;
		n_a     = restart ? '0 : n_raw;

		in_frame = n_a < p_q;
		is_pix   = pix_in.opcode == OP_PIXEL;
		proc_a   = is_pix || !in_frame;   // early flush is dropped
		pix_a    = '0;
		if (is_pix && in_frame)
			pix_a = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};

		wrap_a = (WW'(col_a) + WW'(1)) >= w_q;
		emit_a = n_a >= w1_q;

		// center of the window trails the write point by one line plus one
		if (col_a != '0) begin
			rk_a = row_a - ROW_W'(1);
			ck_a = col_a - CW'(1);
		end else begin
			rk_a = row_a - ROW_W'(2);
			ck_a = wm1_q;
		end
		border_a = (rk_a == '0) || (rk_a >= hm1_q) || (ck_a == '0) || (ck_a >= wm1_q);
		last_a   = (rk_a >= hm1_q) && (ck_a >= wm1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			rowbase_q <= '0;
		end else if (recalc_q == 2'd2) begin
			rowbase_q <= NW'(row_q) * NW'(weff);
		end else if (take) begin
			if (!proc_a || (emit_a && last_a)) begin
				col_q     <= col_a;
				row_q     <= row_a;
				rowbase_q <= rb_a;
				if (proc_a) begin
					col_q     <= '0;
					row_q     <= '0;
					rowbase_q <= '0;
				end
			end else if (wrap_a) begin
				col_q     <= '0;
				row_q     <= row_a + ROW_W'(1);
				rowbase_q <= rb_a + NW'(w_q);
			end else begin
				col_q     <= col_a + CW'(1);
				row_q     <= row_a;
				rowbase_q <= rb_a;
			end
		end
	end

	// ---------------- stage 1: line buffer read data, window shift ----------------
	// mem word: [47:24] upper line, [23:0] middle line
	logic [47:0] line_mem [MAX_WIDTH];
	logic [47:0] rd_s1;
	logic        proc_s1, emit_s1, last_s1, border_s1, fwd_s1;
	pix_t        pix_s1;
	logic [CW-1:0] col_s1;
	pix_t        pix_prev_q, mid_prev_q;
	pix_t        up_eff, mid_eff;

	always_comb begin
		mid_eff = fwd_s1 ? pix_prev_q : pix_t'(rd_s1[23:0]);
		up_eff  = fwd_s1 ? mid_prev_q : pix_t'(rd_s1[47:24]);
	end

	always_ff @(posedge clk) begin
		if (take && proc_a)
			rd_s1 <= line_mem[col_a];
		if (adv && proc_s1)
			line_mem[col_s1] <= {mid_eff, pix_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_s1 <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (adv) begin
			proc_s1 <= take && proc_a;
			emit_s1 <= take && proc_a && emit_a;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take && proc_a) begin
				last_s1   <= last_a;
				border_s1 <= border_a;
				pix_s1    <= pix_a;
				col_s1    <= col_a;
				fwd_s1    <= proc_s1 && (col_s1 == col_a);
			end
			if (proc_s1) begin
				pix_prev_q <= pix_s1;
				mid_prev_q <= mid_eff;
			end
		end
	end

	// window [column][row], column 0 oldest; rows: 0 upper, 1 middle, 2 newest
	pix_t win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					win_q[c][r] <= '0;
		end else if (adv && proc_s1) begin
			win_q[0]    <= win_q[1];
			win_q[1]    <= win_q[2];
			win_q[2][0] <= up_eff;
			win_q[2][1] <= mid_eff;
			win_q[2][2] <= pix_s1;
		end
	end

	// ---------------- stage 2: flags wait for the window ----------------
	logic emit_s2, last_s2, border_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			emit_s2 <= 1'b0;
		else if (adv)
			emit_s2 <= emit_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s2   <= last_s1;
			border_s2 <= border_s1;
		end
	end

	// ---------------- stage 3: sort each window column per channel ----------------
	trio_t lo_s3 [3], md_s3 [3], hi_s3 [3];  // [channel], entries by column
	pix_t  center_s3;
	logic  emit_s3, last_s3, border_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			emit_s3 <= 1'b0;
		else if (adv)
			emit_s3 <= emit_s2;
	end

	always_ff @(posedge clk) begin
		trio_t col_vals, srt;
		if (adv && emit_s2) begin
			for (int ch = 0; ch < 3; ch++) begin
				for (int c = 0; c < 3; c++) begin
					for (int r = 0; r < 3; r++)
						col_vals[r] = win_q[c][r][ch];
					srt = sort3(col_vals);
					lo_s3[ch][c] <= srt[0];
					md_s3[ch][c] <= srt[1];
					hi_s3[ch][c] <= srt[2];
				end
			end
			center_s3 <= win_q[1][1];
			last_s3   <= last_s2;
			border_s3 <= border_s2;
		end
	end

	// ---------------- stage 4: median of nine, output register ----------------
	pix_t med_w;

	always_comb begin
		trio_t m;
		for (int ch = 0; ch < 3; ch++) begin
			m[0] = max3(lo_s3[ch]);
			m[1] = med3(md_s3[ch]);
			m[2] = min3(hi_s3[ch]);
			med_w[ch] = med3(m);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pix_out.valid <= 1'b0;
		else if (adv)
			pix_out.valid <= emit_s3;
	end

	always_ff @(posedge clk) begin
		if (adv && emit_s3) begin
			pix_out.out_red   <= border_s3 ? center_s3[CH_RED]   : med_w[CH_RED];
			pix_out.out_green <= border_s3 ? center_s3[CH_GREEN] : med_w[CH_GREEN];
			pix_out.out_blue  <= border_s3 ? center_s3[CH_BLUE]  : med_w[CH_BLUE];
			pix_out.frame_end <= last_s3;
		end
	end
endmodule
`default_nettype wire

@@ tb/sv/mf3rgb_median_checker.sv @@
// Watches the pixel channels, predicts every filtered word and compares it with the output.
module mf3rgb_median_checker #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire                          cfg_index,
	input  wire [mf3rgb_pkg::CFG_W-1:0]  cfg_data,
	mf3rgb_in_if                         pix_in,
	mf3rgb_out_if                        pix_out,
	output int                           fail_count,
	output int                           outstanding,
	output int                           results_seen
);
	import mf3rgb_pkg::*;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
	} filtered_t;

	filtered_t expected_pixels[$];

	logic [CFG_W-1:0] width_reg, height_reg;
	logic [23:0] upper_row [MAX_WIDTH];
	logic [23:0] middle_row [MAX_WIDTH];
	logic [23:0] win [3][3];
	int unsigned col_pos, row_pos, emitted;

	function automatic logic [CH_W-1:0] median_of_nine(input logic [CH_W-1:0] v [9]);
		logic [CH_W-1:0] s [9];
		logic [CH_W-1:0] x;
		int j;
		for (int i = 0; i < 9; i++) begin
			x = v[i];
			j = i;
			while (j > 0 && s[j-1] > x) begin
				s[j] = s[j-1];
				j--;
			end
			s[j] = x;
		end
		return s[4];
	endfunction

	function automatic logic [CH_W-1:0] window_median(input int lsb);
		logic [CH_W-1:0] v [9];
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				v[r*3+c] = win[r][c][lsb +: CH_W];
		return median_of_nine(v);
	endfunction

	task automatic clear_model();
		width_reg = FRAME_WIDTH_RST;
		height_reg = FRAME_HEIGHT_RST;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_row[i] = '0;
			middle_row[i] = '0;
		end
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				win[r][c] = '0;
		col_pos = 0;
		row_pos = 0;
		emitted = 0;
	endtask

	// one accepted input word; queues the filtered word it releases, if any
	task automatic filter_word(input logic op, input logic [23:0] rgb);
		int unsigned w, h, p, n, c, r, rk, ck;
		logic [23:0] pix, center;
		logic border, last;
		filtered_t res;
		w = width_reg;
		h = height_reg;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h == 0) h = 1;
		p = w * h;
		n = row_pos * w + col_pos;
		if (n > p + w || col_pos >= MAX_WIDTH) begin
			col_pos = 0;
			row_pos = 0;
			emitted = 0;
			n = 0;
		end
		if (op != OP_PIXEL && n < p)
			return;
		pix = (op == OP_PIXEL && n < p) ? rgb : 24'd0;
		c = col_pos;
		r = row_pos;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = upper_row[c];
		win[1][2] = middle_row[c];
		win[2][2] = pix;
		upper_row[c] = middle_row[c];
		middle_row[c] = pix;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end else
			col_pos = c + 1;
		if (n < w + 1)
			return;
		if (c >= 1) begin
			rk = r - 1;
			ck = c - 1;
		end else begin
			rk = r - 2;
			ck = w - 1;
		end
		center = win[1][1];
		border = rk == 0 || rk >= h - 1 || ck == 0 || ck >= w - 1;
		last = rk >= h - 1 && ck >= w - 1;
		if (border) begin
			res.red = center[23:16];
			res.green = center[15:8];
			res.blue = center[7:0];
		end else begin
			res.red = window_median(16);
			res.green = window_median(8);
			res.blue = window_median(0);
		end
		res.frame_end = last;
		expected_pixels.insert(expected_pixels.size(), res);
		emitted = (emitted + 1) & 24'hFFFFFF;
		if (last) begin
			col_pos = 0;
			row_pos = 0;
			emitted = 0;
		end
	endtask

	task automatic count_fail(input string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] MISMATCH %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		filtered_t got, exp_w;
		if (!arst_n) begin
			clear_model();
			expected_pixels.delete();
			fail_count = 0;
			results_seen = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (pix_out.valid && pix_out.ready) begin
				got = {pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.frame_end};
				results_seen++;
				if (expected_pixels.size() == 0)
					count_fail($sformatf("unexpected word rgb=%h end=%b", got[24:1], got.frame_end));
				else begin
					exp_w = expected_pixels.pop_front();
					if (got !== exp_w)
						count_fail($sformatf("word %0d: exp rgb=%h end=%b, got rgb=%h end=%b",
							results_seen, exp_w[24:1], exp_w.frame_end, got[24:1], got.frame_end));
				end
			end
			if (pix_in.valid && pix_in.ready)
				filter_word(pix_in.opcode, {pix_in.in_red, pix_in.in_green, pix_in.in_blue});
			outstanding = expected_pixels.size();
		end
	end
endmodule

@@ tb/sv/tb_top.sv @@
// Stimulus, flow control and verdict for the 3x3 RGB median filter core.
module tb_top;
	import mf3rgb_pkg::*;

	localparam logic OP_FLUSH = ~OP_PIXEL;
	localparam int   PIPE_DRAIN = 8;    // longer than the word pipeline plus geometry rebuild

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	mf3rgb_in_if  pix_in ();
	mf3rgb_out_if pix_out ();

	int fail_count, outstanding, results_seen;

	median_filter_3x3_rgb_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(pix_in), .pix_out(pix_out)
	);

	mf3rgb_median_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix_in(pix_in), .pix_out(pix_out),
		.fail_count(fail_count), .outstanding(outstanding), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Worst run is about 600 words, frame drains and one long hold; 500k
	// time units leave a wide margin.
	initial begin
		#500000;
		$display("Timeout waiting for filtered words");
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------
	// Receiver: the duty cycle is redrawn whenever the phase counter wraps
	// (full speed, medium, heavy stall). A long hold can be requested by the
	// stimulus; it is timed here so the sender keeps offering words and the pipe backs up.
	// ---------------------------------------------------------------
	logic long_hold_req;
	int   hold_cycles_done;

	initial begin
		int duty, phase;
		pix_out.ready = 1'b0;
		hold_cycles_done = 0;
		duty = 100;
		phase = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				pix_out.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_cycles_done += 300;
				long_hold_req = 1'b0;
			end
			if (phase == 0) begin
				case ($urandom_range(0, 2))
					0: duty = 100;
					1: duty = 70;
					default: duty = 25;
				endcase
			end
			phase = (phase + 1) % 64;
			pix_out.ready <= ($urandom_range(1, 100) <= duty);
		end
	end

	// ---------------------------------------------------------------
	// Sender helpers
	// ---------------------------------------------------------------
	int burst_left;
	int words_sent, pixels_sent, flushes_sent, frames_sent;

	// Offer one word and return at the edge that takes it. Between bursts
	// valid mostly drops for a random gap. Ready is judged at the falling edge,
	// where it is stable for the coming rising edge.
	task automatic push_word(input logic op, input logic [23:0] rgb);
		pix_in.valid    <= 1'b1;
		pix_in.opcode   <= op;
		pix_in.in_red   <= rgb[23:16];
		pix_in.in_green <= rgb[15:8];
		pix_in.in_blue  <= rgb[7:0];
		@(negedge clk);
		while (!pix_in.ready) @(negedge clk);
		@(posedge clk);
		words_sent++;
		if (op == OP_PIXEL) pixels_sent++; else flushes_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 3) != 0) begin
				pix_in.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	// Everything predicted has come out; then let in-flight words with no
	// result (early pixels of a frame) settle before touching registers.
	task automatic wait_drained();
		pix_in.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	// write enable stays high; the caller drops it after the last write
	task automatic write_reg(input logic idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
	endtask

	task automatic set_geometry(input int w, input int h);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [23:0] rand_rgb();
		logic [23:0] v;
		case ($urandom_range(0, 4))
			0: v = 24'h000000;
			1: v = 24'hFFFFFF;
			default: v = 24'($urandom());
		endcase
		return v;
	endfunction

	// Whole frame: w*h pixels, then w+1 flushes. Broken variants sprinkle
	// flushes into the pixel run (ignored), replace flushes by pixels
	// (taken as flushes) or cut the frame short.
	task automatic send_frame(input int w, input int h, input bit broken);
		int total, cut;
		total = w * h;
		cut = broken && $urandom_range(0, 2) == 0 ? $urandom_range(0, total + w) : total + w + 1;
		for (int i = 0; i < total + w + 1 && i < cut; i++) begin
			if (broken && i < total && $urandom_range(0, 9) == 0)
				push_word(OP_FLUSH, rand_rgb());
			if (i < total)
				push_word(OP_PIXEL, rand_rgb());
			else if (broken && $urandom_range(0, 4) == 0)
				push_word(OP_PIXEL, rand_rgb());
			else
				push_word(OP_FLUSH, rand_rgb());
		end
		frames_sent++;
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		int w, h;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.opcode = OP_PIXEL;
		pix_in.in_red = '0;
		pix_in.in_green = '0;
		pix_in.in_blue = '0;
		long_hold_req = 1'b0;
		burst_left = 0;
		words_sent = 0; pixels_sent = 0; flushes_sent = 0; frames_sent = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 3x3 frame, center interior, channel extremes; one early
		// flush that must be ignored, one extra pixel in the flush tail.
		set_geometry(3, 3);
		push_word(OP_PIXEL, 24'h000000);
		push_word(OP_PIXEL, 24'hFFFFFF);
		push_word(OP_PIXEL, 24'hFF00FF);
		push_word(OP_FLUSH, 24'h123456);
		push_word(OP_PIXEL, 24'h00FF00);
		push_word(OP_PIXEL, 24'h808080);
		push_word(OP_PIXEL, 24'h7F7F7F);
		push_word(OP_PIXEL, 24'hFFFFFF);
		push_word(OP_PIXEL, 24'h010203);
		push_word(OP_PIXEL, 24'hFEFDFC);
		push_word(OP_FLUSH, 24'h0);
		push_word(OP_PIXEL, 24'hAAAAAA);
		push_word(OP_FLUSH, 24'h0);
		push_word(OP_FLUSH, 24'h0);
		frames_sent++;
		// single row: first flush yields nothing
		set_geometry(4, 1);
		send_frame(4, 1, 0);

		// Random frames, mostly small. The first one runs under a long
		// receiver hold so the input side stalls.
		set_geometry(8, 6);
		long_hold_req = 1'b1;
		send_frame(8, 6, 0);
		while (words_sent < 400) begin
			w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 20);
			h = $urandom_range(1, 6);
			set_geometry(w, h);
			send_frame(w, h, $urandom_range(0, 4) == 0);
		end

		// Register extremes: zero acts as one, an oversize width clamps.
		// The clamped frame is only started; the next geometry restarts it.
		set_geometry(0, 0);
		send_frame(1, 1, 0);
		set_geometry(4095, 4095);
		for (int i = 0; i < 40; i++)
			push_word(OP_PIXEL, rand_rgb());
		set_geometry(1, 6);
		send_frame(1, 6, 0);
		set_geometry(3, 3);
		send_frame(3, 3, 1);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Covered %0d frames: %0d pixels, %0d flushes, %0d filtered words checked",
			frames_sent, pixels_sent, flushes_sent, results_seen);
		$display("Registers from zero up to a clamped 4095 width, long output hold of %0d cycles",
			hold_cycles_done);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

@@ median_filter_3x3_rgb_core.f @@
rtl/mf3rgb_pkg.sv
rtl/mf3rgb_if.sv
rtl/median_filter_3x3_rgb_core.sv
tb/sv/mf3rgb_median_checker.sv
tb/sv/tb_top.sv
